// ===== rtl/core/esgr_pkg.sv =====
`default_nettype none
package esgr_pkg;

    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int REM_BITS  = WORD_BITS + 1;

    localparam logic [WORD_BITS-1:0] WORD_SIGN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [1:0] XM_COPY     = 2'd0;
    localparam logic [1:0] XM_DISCRETE = 2'd1;
    localparam logic [1:0] XM_MEAN     = 2'd2;

    localparam logic [1:0] SM_COPY     = 2'd0;
    localparam logic [1:0] SM_DISCRETE = 2'd1;
    localparam logic [1:0] SM_MEAN     = 2'd2;
    localparam logic [1:0] SM_GEO      = 2'd3;

    localparam logic REG_X_MODE     = 1'b0;
    localparam logic REG_SIGMA_MODE = 1'b1;

    typedef struct packed {
        logic [1:0] x_mode;
        logic [1:0] sigma_mode;
    } cfg_t;

    typedef struct packed {
        logic [31:0]          x_child;
        logic [WORD_BITS-1:0] s_pick;
        logic                 geo;
        logic                 s_present;
        logic                 last;
    } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/es_gene_recombination.sv =====
// Channel  Direction  tdata                                   tuser                      tlast
// s_       in         x_first, x_second, s_first, s_second    sigma_valid, coin_x, coin_s last
// m_       out        x_child, s_child                        s_present                  last_out
// APB      in         x_mode at 0x0, sigma_mode at 0x4
//
// One word per cycle in and out while m_tready does not stall the output.
// The square-root pipeline produces one root bit per stage.
// Synchronous active-low reset clears all valid bits and the mode registers.
// A stall on m_tready freezes every stage; s_tready drops in the same cycle.
`default_nettype none
module es_gene_recombination (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // x_first[31:0], x_second[63:32], s_first[95:64], s_second[127:96]
    input  wire logic [127:0]  s_tdata,
    // sigma_valid[0], coin_x[1], coin_s[2]
    input  wire logic [2:0]    s_tuser,
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // x_child[31:0], s_child[63:32]
    output logic [63:0]        m_tdata,
    // s_present[0]
    output logic               m_tuser,
    output logic               m_tlast,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);
    import esgr_pkg::*;

    cfg_t                 cfg;
    logic                 advance;
    logic                 fr_valid;
    side_t                fr_side;
    logic [PROD_BITS-1:0] fr_prod;
    logic                 sq_valid;
    side_t                sq_side;
    logic [WORD_BITS-1:0] sq_root;
    logic [WORD_BITS-1:0] s_res;

    logic                 m_tvalid_reg;
    logic [63:0]          m_tdata_reg;
    logic [63:0]          m_tdata_next;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    esgr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    esgr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .x_first     (s_tdata[31:0]),
        .x_second    (s_tdata[63:32]),
        .s_first     (s_tdata[95:64]),
        .s_second    (s_tdata[127:96]),
        .sigma_valid (s_tuser[0]),
        .coin_x      (s_tuser[1]),
        .coin_s      (s_tuser[2]),
        .last        (s_tlast),
        .out_valid   (fr_valid),
        .out_side    (fr_side),
        .out_prod    (fr_prod)
    );

    esgr_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_prod   (fr_prod),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    always_comb begin
        s_res        = sq_side.geo ? sq_root : sq_side.s_pick;
        m_tdata_next = {(sq_side.s_present ? 32'(s_res) : 32'd0), sq_side.x_child};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= sq_side.s_present;
            m_tlast_reg <= sq_side.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

// ===== rtl/core/esgr_cfg.sv =====
`default_nettype none
module esgr_cfg (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    output esgr_pkg::cfg_t    cfg
);
    import esgr_pkg::*;

    logic [1:0] x_mode_reg;
    logic [1:0] sigma_mode_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_mode_reg     <= XM_COPY;
            sigma_mode_reg <= SM_COPY;
        end else if (wr_en) begin
            if (paddr[2] == REG_X_MODE) begin
                x_mode_reg <= pwdata[1:0];
            end else begin
                sigma_mode_reg <= pwdata[1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SIGMA_MODE) begin
            prdata[1:0] = sigma_mode_reg;
        end else begin
            prdata[1:0] = x_mode_reg;
        end
    end

    assign cfg.x_mode     = x_mode_reg;
    assign cfg.sigma_mode = sigma_mode_reg;

endmodule
`default_nettype wire

// ===== rtl/core/esgr_front.sv =====
`default_nettype none
module esgr_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            advance,
    input  wire esgr_pkg::cfg_t                  cfg,
    input  wire logic                            in_valid,
    input  wire logic [31:0]                     x_first,
    input  wire logic [31:0]                     x_second,
    input  wire logic [31:0]                     s_first,
    input  wire logic [31:0]                     s_second,
    input  wire logic                            sigma_valid,
    input  wire logic                            coin_x,
    input  wire logic                            coin_s,
    input  wire logic                            last,
    output logic                                 out_valid,
    output esgr_pkg::side_t                      out_side,
    output logic [esgr_pkg::PROD_BITS-1:0]       out_prod
);
    import esgr_pkg::*;

    logic                        valid_reg;
    side_t                       side_reg;
    side_t                       side_next;
    logic [PROD_BITS-1:0]        prod_reg;
    logic [PROD_BITS-1:0]        prod_next;
    logic [WORD_BITS-1:0]        xa;
    logic [WORD_BITS-1:0]        xb;
    logic [WORD_BITS-1:0]        sa;
    logic [WORD_BITS-1:0]        sb;
    logic [WORD_BITS:0]          x_sum;
    logic [WORD_BITS:0]          s_sum;
    logic [WORD_BITS-1:0]        xo;
    logic signed [WORD_BITS-1:0] xw;
    logic                        cs;

    always_comb begin
        xa    = x_first[WORD_BITS-1:0] ^ WORD_SIGN;
        xb    = x_second[WORD_BITS-1:0] ^ WORD_SIGN;
        sa    = s_first[WORD_BITS-1:0];
        sb    = s_second[WORD_BITS-1:0];
        x_sum = {1'b0, xa} + {1'b0, xb};
        s_sum = {1'b0, sa} + {1'b0, sb};
        cs    = (cfg.x_mode == XM_DISCRETE && cfg.sigma_mode == SM_DISCRETE) ? coin_x : coin_s;

        case (cfg.x_mode)
            XM_DISCRETE: xo = coin_x ? xa : xb;
            XM_MEAN:     xo = x_sum[WORD_BITS:1];
            default:     xo = xa;
        endcase
        xw = xo ^ WORD_SIGN;

        side_next.x_child = 32'(xw);
        case (cfg.sigma_mode)
            SM_DISCRETE: side_next.s_pick = cs ? sa : sb;
            SM_MEAN:     side_next.s_pick = s_sum[WORD_BITS:1];
            default:     side_next.s_pick = sa;
        endcase
        side_next.geo       = (cfg.sigma_mode == SM_GEO);
        side_next.s_present = sigma_valid;
        side_next.last      = last;

        prod_next = PROD_BITS'(sa) * PROD_BITS'(sb);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg <= side_next;
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_prod  = prod_reg;

endmodule
`default_nettype wire

// ===== rtl/core/esgr_sqrt.sv =====
`default_nettype none
module esgr_sqrt (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            advance,
    input  wire logic                            in_valid,
    input  wire esgr_pkg::side_t                 in_side,
    input  wire logic [esgr_pkg::PROD_BITS-1:0]  in_prod,
    output logic                                 out_valid,
    output esgr_pkg::side_t                      out_side,
    output logic [esgr_pkg::WORD_BITS-1:0]       out_root
);
    import esgr_pkg::*;

    logic                 valid_reg [0:WORD_BITS-1];
    side_t                side_reg  [0:WORD_BITS-1];
    logic [WORD_BITS-1:0] root_reg  [0:WORD_BITS-1];
    logic [REM_BITS-1:0]  rem_reg   [0:WORD_BITS-2];
    logic [PROD_BITS-1:0] rad_reg   [0:WORD_BITS-2];

    logic                 cur_valid [0:WORD_BITS-1];
    side_t                cur_side  [0:WORD_BITS-1];
    logic [WORD_BITS-1:0] cur_root  [0:WORD_BITS-1];
    logic [REM_BITS-1:0]  cur_rem   [0:WORD_BITS-1];
    logic [PROD_BITS-1:0] cur_rad   [0:WORD_BITS-1];

    for (genvar k = 0; k < WORD_BITS; k++) begin : g_stage
        logic [REM_BITS+1:0]  work;
        logic [REM_BITS+1:0]  trial;
        logic                 take;
        logic [WORD_BITS-1:0] root_next;

        if (k == 0) begin : g_first
            assign cur_valid[k] = in_valid;
            assign cur_side[k]  = in_side;
            assign cur_root[k]  = '0;
            assign cur_rem[k]   = '0;
            assign cur_rad[k]   = in_prod;
        end else begin : g_chain
            assign cur_valid[k] = valid_reg[k-1];
            assign cur_side[k]  = side_reg[k-1];
            assign cur_root[k]  = root_reg[k-1];
            assign cur_rem[k]   = rem_reg[k-1];
            assign cur_rad[k]   = rad_reg[k-1];
        end

        always_comb begin
            work      = {cur_rem[k], cur_rad[k][PROD_BITS-1 -: 2]};
            trial     = {1'b0, cur_root[k], 2'b01};
            take      = (work >= trial);
            root_next = {cur_root[k][WORD_BITS-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (advance) begin
                valid_reg[k] <= cur_valid[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                side_reg[k] <= cur_side[k];
                root_reg[k] <= root_next;
            end
        end

        if (k < WORD_BITS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (advance) begin
                    rem_reg[k] <= take ? REM_BITS'(work - trial) : REM_BITS'(work);
                    rad_reg[k] <= cur_rad[k] << 2;
                end
            end
        end
    end

    assign out_valid = valid_reg[WORD_BITS-1];
    assign out_side  = side_reg[WORD_BITS-1];
    assign out_root  = root_reg[WORD_BITS-1];

endmodule
`default_nettype wire
